### rtl/strongest_device_table_core_macros.svh
// assertion helpers used by the top-level core file
`ifndef STRONGEST_DEVICE_TABLE_CORE_MACROS_SVH
`define STRONGEST_DEVICE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SDT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdt_pkg.sv
`default_nettype none

package sdt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;
  localparam int unsigned MAC_W           = 48;
  localparam int unsigned LEVEL_W         = 8;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned SLOT_W          = 4;
  localparam int unsigned ACTION_W        = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_IMPROVED = 3'd0,
    ACT_KEPT     = 3'd1,
    ACT_FILLED   = 3'd2,
    ACT_REPLACED = 3'd3,
    ACT_DROPPED  = 3'd4,
    ACT_READ     = 3'd5
  } action_e;

  typedef struct packed {
    logic                      operation;
    logic [MAC_W-1:0]          device_mac;
    logic signed [LEVEL_W-1:0] signal_level;
    logic [KIND_W-1:0]         device_kind;
    logic [TIME_W-1:0]         seen_time;
    logic [SLOT_W-1:0]         read_slot;
  } in_beat_t;

  typedef struct packed {
    action_e                   action;
    logic [SLOT_W-1:0]         slot_index;
    logic                      entry_valid;
    logic [MAC_W-1:0]          entry_mac;
    logic signed [LEVEL_W-1:0] entry_level;
    logic [KIND_W-1:0]         entry_kind;
    logic [TIME_W-1:0]         entry_time;
  } out_beat_t;

  typedef struct packed {
    logic [MAC_W-1:0]          mac;
    logic signed [LEVEL_W-1:0] level;
    logic [KIND_W-1:0]         kind;
    logic [TIME_W-1:0]         stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic slot_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/strongest_device_table_core.sv
`default_nettype none

// Strongest-device table: TABLE_SLOTS entries of mac, level, kind and last-seen time,
// held in a slot memory with one read and one write port that the block scans one
// slot per cycle. A detection runs from accept through a setup step, one memory read
// per slot, a step for read latency and the decision; a slot read goes from accept
// through a setup step that reads the slot to the decision. The result sits in an
// output register, and the block only waits in its decision step while that register
// still holds an untaken beat. Reset empties the table at once through per-slot valid
// bits, so there is no clearing pass.
module strongest_device_table_core #(
  parameter int unsigned TABLE_SLOTS = sdt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sdt_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sdt_pkg::out_beat_t      out_data_o
);

  sdt_pkg::cmd_t cmd;
  sdt_pkg::sts_t sts;

  logic in_accept;
  logic out_dropped;
  logic drop_fields_zero;
  logic valid_agrees;

  sdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sdt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign in_accept        = in_valid_i && in_ready_o;
  assign out_dropped      = out_valid_o && (out_data_o.action == sdt_pkg::ACT_DROPPED);
  assign drop_fields_zero = (out_data_o.slot_index == '0) && !out_data_o.entry_valid &&
                            (out_data_o.entry_mac == '0) && (out_data_o.entry_time == '0);
  assign valid_agrees     = (out_data_o.entry_valid == (out_data_o.entry_level != '0));

`include "strongest_device_table_core_macros.svh"

  `SDT_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready_o, "ready after accept")
  `SDT_ASSERT_NOW(a_drop_clean, out_dropped, drop_fields_zero, "dropped beat carries data")
  `SDT_ASSERT_NOW(a_valid_level, out_valid_o, valid_agrees, "valid flag disagrees with level")

endmodule

`default_nettype wire

### rtl/sdt_ctrl.sv
`default_nettype none

module sdt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output sdt_pkg::cmd_t      cmd_o,
  input  wire sdt_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_TAIL,
    S_DEC
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_START;
        end
        S_START: begin
          state_q <= sts_i.op_read ? S_DEC : S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_TAIL;
        end
        S_TAIL: begin
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      S_START: begin
        cmd_o.slot_rd = sts_i.op_read;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      S_TAIL: begin
      end
      S_DEC: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sdt_dp.sv
`default_nettype none

module sdt_dp #(
  parameter int unsigned TABLE_SLOTS = sdt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdt_pkg::in_beat_t in_data_i,
  input  wire sdt_pkg::cmd_t     cmd_i,
  output sdt_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sdt_pkg::out_beat_t     out_data_o
);

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SW = sdt_pkg::SLOT_W;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SLOTS - 1);

  sdt_pkg::entry_t mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_q;

  sdt_pkg::in_beat_t  in_q;
  logic [AW-1:0]      cnt_q;
  logic               eval_q;
  logic [AW-1:0]      eval_idx_q;
  sdt_pkg::entry_t    rd_entry_q;
  logic               rd_valid_q;

  logic               found_q;
  logic [AW-1:0]      found_idx_q;
  sdt_pkg::entry_t    found_entry_q;
  logic               empty_q;
  logic [AW-1:0]      pick_idx_q;
  logic signed [sdt_pkg::LEVEL_W-1:0] pick_level_q;
  logic signed [sdt_pkg::LEVEL_W-1:0] worst_q;

  logic               out_valid_q;
  sdt_pkg::out_beat_t out_q;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  sdt_pkg::entry_t    ev_entry;
  logic               ev_match;
  logic               ev_empty;
  logic               slot_ok;
  logic               improve;
  logic               pick_win;
  logic               wr_en;
  logic [AW-1:0]      wr_idx;
  sdt_pkg::entry_t    wr_entry;
  sdt_pkg::out_beat_t res;

  function automatic sdt_pkg::out_beat_t show(sdt_pkg::action_e act, logic [SW-1:0] idx,
                                              sdt_pkg::entry_t e);
    sdt_pkg::out_beat_t b;
    b.action      = act;
    b.slot_index  = idx;
    b.entry_valid = (e.level != '0);
    b.entry_mac   = e.mac;
    b.entry_level = e.level;
    b.entry_kind  = e.kind;
    b.entry_time  = e.stamp;
    return b;
  endfunction

  assign rd_en   = cmd_i.scan_rd | cmd_i.slot_rd;
  assign rd_addr = cmd_i.slot_rd ? AW'(in_q.read_slot) : cnt_q;

  assign ev_entry = rd_valid_q ? rd_entry_q : '0;
  assign ev_match = (ev_entry.mac == in_q.device_mac);
  assign ev_empty = (ev_entry.level == '0);

  assign slot_ok  = (32'(in_q.read_slot) < 32'(TABLE_SLOTS));
  assign improve  = $signed(in_q.signal_level) > $signed(found_entry_q.level);
  assign pick_win = (pick_level_q == '0) || ($signed(in_q.signal_level) > $signed(pick_level_q));

  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = found_idx_q;
    wr_entry.mac   = in_q.device_mac;
    wr_entry.level = in_q.signal_level;
    wr_entry.kind  = in_q.device_kind;
    wr_entry.stamp = in_q.seen_time;
    res            = show(sdt_pkg::ACT_DROPPED, '0, '0);
    if (in_q.operation) begin
      res = show(sdt_pkg::ACT_READ, in_q.read_slot, (slot_ok && rd_valid_q) ? rd_entry_q : '0);
    end else if (found_q) begin
      if (improve) begin
        wr_en         = cmd_i.commit;
        wr_entry.kind = found_entry_q.kind;
        res           = show(sdt_pkg::ACT_IMPROVED, SW'(found_idx_q), wr_entry);
      end else begin
        res = show(sdt_pkg::ACT_KEPT, SW'(found_idx_q), found_entry_q);
      end
    end else if (pick_win) begin
      wr_en  = cmd_i.commit;
      wr_idx = pick_idx_q;
      res    = show((pick_level_q == '0) ? sdt_pkg::ACT_FILLED : sdt_pkg::ACT_REPLACED,
                    SW'(pick_idx_q), wr_entry);
    end
  end

  // slot storage, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_entry;
    if (rd_en) rd_entry_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_idx] <= 1'b1;
      if (rd_en) rd_valid_q <= valid_q[rd_addr];
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      eval_q <= cmd_i.scan_rd;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.scan_rd) eval_idx_q <= cnt_q;
    if (cmd_i.commit) out_q <= res;
    if (eval_q) begin
      if (eval_idx_q == '0) begin
        found_q       <= ev_match;
        found_idx_q   <= '0;
        found_entry_q <= ev_entry;
        empty_q       <= ev_empty;
        pick_idx_q    <= '0;
        pick_level_q  <= ev_entry.level;
        worst_q       <= ($signed(ev_entry.level) < 0) ? ev_entry.level : '0;
      end else begin
        if (!found_q && ev_match) begin
          found_q       <= 1'b1;
          found_idx_q   <= eval_idx_q;
          found_entry_q <= ev_entry;
        end
        if (!empty_q) begin
          if (ev_empty) begin
            empty_q      <= 1'b1;
            pick_idx_q   <= eval_idx_q;
            pick_level_q <= '0;
          end else if ($signed(ev_entry.level) < $signed(worst_q)) begin
            worst_q      <= ev_entry.level;
            pick_idx_q   <= eval_idx_q;
            pick_level_q <= ev_entry.level;
          end
        end
      end
    end
  end

  assign sts_o.op_read   = in_q.operation;
  assign sts_o.scan_last = (cnt_q == LastIdx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
